// File: hdl/brb_pkg.sv
package brb_pkg;

   // fixed field widths
   localparam int CNT_W    = 13;
   localparam int OPCODE_W = 2;
   localparam int DATA_W   = 8;
   localparam int LEN_W    = 7;
   localparam int OFF_W    = 12;

   // parameter defaults
   localparam int DEPTH_DEFAULT     = 4096;
   localparam int MAX_BURST_DEFAULT = 64;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_PEEK  = 2'd2;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DECODE = 3'b010,
      ST_BURST  = 3'b100
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture request word
      logic decode;   // size the item, do a byte write
      logic burst;    // issue one byte of a burst
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic dec_empty;   // item gives a single empty result
      logic burst_done;  // this is the final byte of the burst
   } status_type;

endpackage

// File: hdl/byte_ring_buffer_with_peek.sv
// A write, or a read/peek that moves nothing, gives its one word, registered
//   from the decode state; a burst of N bytes gives one byte per cycle from
//   the burst state, each registered with its byte store read.
// Busy covers decode (write/empty) or decode and burst; no new item is taken
//   while busy, and the byte store's single read port sets the burst pace.
// Reset: synchronous, active high; store emptied, capacity back to DEPTH (max
//   2**CNT_W-1), byte data kept. The receiver cannot stall the result strobe.
module byte_ring_buffer_with_peek
   import brb_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int MAX_BURST = MAX_BURST_DEFAULT
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [DATA_W-1:0]   req_wr_data,
   input  logic [LEN_W-1:0]    req_burst_length,
   input  logic [OFF_W-1:0]    req_peek_offset,
   input  logic                csr_wr_en,
   input  logic [CNT_W-1:0]    csr_wr_data,
   output logic                rsp_strobe,
   output logic [DATA_W-1:0]   rsp_rd_data,
   output logic                rsp_data_valid,
   output logic                rsp_last,
   output logic [LEN_W-1:0]    rsp_moved_count,
   output logic [CNT_W-1:0]    rsp_used_space,
   output logic [CNT_W-1:0]    rsp_free_space
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   brb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // ring store and result path
   brb_datapath #(
      .DEPTH     (DEPTH),
      .MAX_BURST (MAX_BURST)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_opcode),
      .req_wr_data      (req_wr_data),
      .req_burst_length (req_burst_length),
      .req_peek_offset  (req_peek_offset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_rd_data      (rsp_rd_data),
      .rsp_data_valid   (rsp_data_valid),
      .rsp_last         (rsp_last),
      .rsp_moved_count  (rsp_moved_count),
      .rsp_used_space   (rsp_used_space),
      .rsp_free_space   (rsp_free_space)
   );

endmodule

// File: hdl/brb_ctrl.sv
module brb_ctrl
   import brb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = status.dec_empty ? ST_IDLE : ST_BURST;
         end
         ST_BURST: begin
            if (status.burst_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // commands
   assign busy       = (state_ff != ST_IDLE);
   assign cmd.load   = (state_ff == ST_IDLE) && start;
   assign cmd.decode = (state_ff == ST_DECODE);
   assign cmd.burst  = (state_ff == ST_BURST);

endmodule

// File: hdl/brb_datapath.sv
module brb_datapath
   import brb_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int MAX_BURST = MAX_BURST_DEFAULT
)(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [DATA_W-1:0]   req_wr_data,
   input  logic [LEN_W-1:0]    req_burst_length,
   input  logic [OFF_W-1:0]    req_peek_offset,
   input  logic                csr_wr_en,
   input  logic [CNT_W-1:0]    csr_wr_data,
   output logic                rsp_strobe,
   output logic [DATA_W-1:0]   rsp_rd_data,
   output logic                rsp_data_valid,
   output logic                rsp_last,
   output logic [LEN_W-1:0]    rsp_moved_count,
   output logic [CNT_W-1:0]    rsp_used_space,
   output logic [CNT_W-1:0]    rsp_free_space
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int AW    = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
   localparam int CAP_RESET = (DEPTH < (2**CNT_W - 1)) ? DEPTH : (2**CNT_W - 1);
   localparam logic [AW-1:0]    DEPTH_A   = AW'(DEPTH);
   localparam logic [LEN_W-1:0] BURST_MAX = LEN_W'(MAX_BURST);

   // byte store, one write and one registered read port
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] mem_q_ff;

   // ring state
   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   // captured request word
   logic [OPCODE_W-1:0] op_ff;
   logic [DATA_W-1:0]   wdata_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [OFF_W-1:0]    off_ff;

   // burst walk
   logic [PTR_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic [LEN_W-1:0] total_ff, total_in;

   // result registers
   logic             strobe_ff, strobe_in;
   logic             valid_ff, valid_in;
   logic             last_ff, last_in;
   logic [LEN_W-1:0] moved_ff, moved_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] free_ff, free_in;

   // decode terms
   logic             is_read, is_peek, is_write;
   logic             full;
   logic             mem_we;
   logic [LEN_W-1:0] rd_len, pk_len, eff_len;
   logic [CNT_W-1:0] avail;
   logic [AW-1:0]    pk_sum;
   logic [PTR_W-1:0] start_addr;
   logic [AW-1:0]    wp_inc, addr_inc;
   logic [PTR_W-1:0] wp_adv, addr_adv;
   logic [CNT_W-1:0] cfg_cap;

   // decode the captured item
   always_comb begin
      is_write = 1'b0;
      is_read  = 1'b0;
      is_peek  = 1'b0;
      case (op_ff)
         OP_WRITE: is_write = 1'b1;
         OP_READ:  is_read  = 1'b1;
         OP_PEEK:  is_peek  = 1'b1;
         default:  ;
      endcase
   end

   assign full = (fill_ff >= cap_ff);

   // read: cut to fill count
   assign rd_len = (CNT_W'(len_ff) > fill_ff) ? fill_ff[LEN_W-1:0] : len_ff;

   // peek: nothing at or past the count, else cut at the count
   assign avail = fill_ff - CNT_W'(off_ff);
   always_comb begin
      if ((CNT_W'(off_ff) >= fill_ff) || (len_ff == '0)) pk_len = '0;
      else if (CNT_W'(len_ff) > avail)                     pk_len = avail[LEN_W-1:0];
      else                                                 pk_len = len_ff;
   end

   assign eff_len = is_read ? rd_len : (is_peek ? pk_len : '0);

   // peek start, wrapped once at capacity
   assign pk_sum     = AW'(rp_ff) + AW'(off_ff);
   assign start_addr = is_peek ? ((pk_sum >= AW'(cap_ff)) ? PTR_W'(pk_sum - AW'(cap_ff))
                                                          : PTR_W'(pk_sum))
                               : rp_ff;

   // pointer advance with wrap at capacity
   assign wp_inc   = AW'(wp_ff) + AW'(1);
   assign wp_adv   = (wp_inc >= AW'(cap_ff)) ? '0 : PTR_W'(wp_inc);
   assign addr_inc = AW'(addr_ff) + AW'(1);
   assign addr_adv = (addr_inc >= AW'(cap_ff)) ? '0 : PTR_W'(addr_inc);

   // capacity write clamped to 1..DEPTH
   always_comb begin
      if (csr_wr_data == '0)            cfg_cap = CNT_W'(1);
      else if (AW'(csr_wr_data) > DEPTH_A) cfg_cap = CNT_W'(DEPTH);
      else                              cfg_cap = csr_wr_data;
   end

   assign mem_we = cmd.decode && is_write && !full;

   assign status.dec_empty  = (eff_len == '0);
   assign status.burst_done = (remain_ff == LEN_W'(1));

   // next state of ring and result registers
   always_comb begin
      cap_in    = cap_ff;
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      fill_in   = fill_ff;
      addr_in   = addr_ff;
      remain_in = remain_ff;
      total_in  = total_ff;
      strobe_in = 1'b0;
      valid_in  = valid_ff;
      last_in   = last_ff;
      moved_in  = moved_ff;
      used_in   = used_ff;
      free_in   = free_ff;

      if (csr_wr_en) begin
         cap_in  = cfg_cap;
         wp_in   = '0;
         rp_in   = '0;
         fill_in = '0;
      end else if (cmd.decode) begin
         if (mem_we) begin
            wp_in   = wp_adv;
            fill_in = fill_ff + CNT_W'(1);
         end
         addr_in   = start_addr;
         remain_in = eff_len;
         total_in  = eff_len;
         if (eff_len == '0) begin
            strobe_in = 1'b1;
            valid_in  = 1'b0;
            last_in   = 1'b1;
            moved_in  = mem_we ? LEN_W'(1) : '0;
            used_in   = fill_in;
            free_in   = cap_ff - fill_in;
         end
      end else if (cmd.burst) begin
         addr_in   = addr_adv;
         remain_in = remain_ff - LEN_W'(1);
         if (is_read) begin
            rp_in   = addr_adv;
            fill_in = fill_ff - CNT_W'(1);
         end
         strobe_in = 1'b1;
         valid_in  = 1'b1;
         last_in   = status.burst_done;
         moved_in  = status.burst_done ? total_ff : '0;
         used_in   = fill_in;
         free_in   = cap_ff - fill_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CNT_W'(CAP_RESET);
         wp_ff     <= '0;
         rp_ff     <= '0;
         fill_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         cap_ff    <= cap_in;
         wp_ff     <= wp_in;
         rp_ff     <= rp_in;
         fill_ff   <= fill_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         wdata_ff <= req_wr_data;
         len_ff   <= (req_burst_length > BURST_MAX) ? BURST_MAX : req_burst_length;
         off_ff   <= req_peek_offset;
      end
      addr_ff   <= addr_in;
      remain_ff <= remain_in;
      total_ff  <= total_in;
      valid_ff  <= valid_in;
      last_ff   <= last_in;
      moved_ff  <= moved_in;
      used_ff   <= used_in;
      free_ff   <= free_in;
   end

   // byte store ports
   always_ff @(posedge clock) begin
      if (mem_we) mem[wp_ff] <= wdata_ff;
   end

   always_ff @(posedge clock) begin
      mem_q_ff <= mem[addr_ff];
   end

   // result word
   assign rsp_strobe      = strobe_ff;
   assign rsp_data_valid  = valid_ff;
   assign rsp_rd_data     = valid_ff ? mem_q_ff : '0;
   assign rsp_last        = last_ff;
   assign rsp_moved_count = moved_ff;
   assign rsp_used_space  = used_ff;
   assign rsp_free_space  = free_ff;

endmodule

// File: hdl/brb_checker.sv
module brb_checker
   import brb_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input logic             rsp_data_valid,
   input logic             rsp_last,
   input logic [LEN_W-1:0] rsp_moved_count
);

   // an accepted word always raises busy in the cycle after it is accepted
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accepted word");

   // a word without data is always the final one of its item
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data_valid |-> rsp_last)
      else $error("empty result word not marked last");

   // moved count only on the final word
   a_moved_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> rsp_moved_count == '0)
      else $error("moved count on non-final word");

   // the final word coincides with the block going idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> !busy)
      else $error("busy still high on final word");

   // no word appears while idle except a final one
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy && rsp_strobe |-> rsp_last)
      else $error("stray result word while idle");

endmodule

bind byte_ring_buffer_with_peek brb_checker u_brb_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_data_valid  (rsp_data_valid),
   .rsp_last        (rsp_last),
   .rsp_moved_count (rsp_moved_count)
);
